FILE: rtl/misu_pkg.sv
// shared types and constants for the minimal interval set update unit
package misu_pkg;

  localparam int SLOTS_DEF     = 64;
  localparam int TIME_BITS_DEF = 16;
  localparam int FIELD_T_W     = 16;
  localparam int UTIL_W        = 32;
  localparam int SUM_W         = 48;
  localparam int CNT_OUT_W     = 7;
  localparam int STATUS_W      = 2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_NESTED = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRAP,
    S_SUB,
    S_ADD,
    S_DONE
  } fsm_e;

  typedef struct packed {
    logic clear;
    logic sub;
    logic add;
  } acc_cmd_t;

endpackage

FILE: rtl/misu_if.sv
// item channel interfaces for the input and result streams
interface misu_in_if import misu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [FIELD_T_W-1:0] occ_start;
  logic [FIELD_T_W-1:0] occ_end;
  logic [UTIL_W-1:0]    occ_utility;

  modport source (output valid, output mode, output occ_start, output occ_end,
                  output occ_utility, input ready);
  modport sink   (input valid, input mode, input occ_start, input occ_end,
                  input occ_utility, output ready);
endinterface

interface misu_out_if import misu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [CNT_OUT_W-1:0] removed_count;
  logic [CNT_OUT_W-1:0] entry_count;
  logic [SUM_W-1:0]     total_utility;

  modport source (output valid, output status, output removed_count,
                  output entry_count, output total_utility, input ready);
  modport sink   (input valid, input status, input removed_count,
                  input entry_count, input total_utility, output ready);
endinterface

FILE: rtl/misu_ram.sv
// generic single-port-write, single-port-read ram with registered read
module misu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/misu_acc.sv
// saturating utility total and held interval count
module misu_acc import misu_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  acc_cmd_t                      cmd_i,
  input  logic [UTIL_W+$clog2(SLOTS+1)-1:0] sub_val_i,
  input  logic [$clog2(SLOTS+1)-1:0]    sub_cnt_i,
  input  logic [UTIL_W-1:0]             add_val_i,
  output logic [SUM_W-1:0]              total_o,
  output logic [$clog2(SLOTS+1)-1:0]    count_o
);

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  logic [SUM_W-1:0] total_q, total_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0] sub_ext, add_ext;

  assign sub_ext = SUM_W'(sub_val_i);
  assign add_ext = SUM_W'(add_val_i);

  always_comb begin
    total_d = total_q;
    count_d = count_q;
    if (cmd_i.clear) begin
      total_d = '0;
      count_d = '0;
    end else if (cmd_i.sub) begin
      total_d = (sub_ext >= total_q) ? '0 : (total_q - sub_ext);
      count_d = count_q - sub_cnt_i;
    end else if (cmd_i.add) begin
      total_d = (add_ext >= (SUM_MAX - total_q)) ? SUM_MAX : (total_q + add_ext);
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      count_q <= '0;
    end else begin
      total_q <= total_d;
      count_q <= count_d;
    end
  end

  assign total_o = total_q;
  assign count_o = count_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(SLOTS))
    else $error("held count above slot count");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (total_q == '0) && (count_q == '0))
    else $error("clear left a nonzero total or count");
`endif

endmodule

FILE: rtl/minimal_interval_set_update_unit.sv
// top level: interval set update with slot ram scan and result register
//
//   channel | dir | payload
//   in_i    | in  | mode, occ_start, occ_end, occ_utility
//   out_o   | out | status, removed_count, entry_count, total_utility
//
// an insert reads one slot ram word per cycle over all slots, then does the
// read drain, removal, store and result load; a clear goes from idle straight to result load
// the ram port bounds the scan; slot valid bits are flops cleared by reset
// a waiting result holds the done state until out_o takes the previous item
module minimal_interval_set_update_unit import misu_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  misu_in_if.sink    in_i,
  misu_out_if.source out_o
);

  localparam int AW    = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int REM_W = UTIL_W + CNT_W;
  localparam int WORD_W = 2 * TIME_BITS + UTIL_W;
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  fsm_e state_q, state_d;

  logic [TIME_BITS-1:0] s_q, e_q;
  logic [UTIL_W-1:0]    u_q;
  logic [AW-1:0]        addr_q;
  logic [AW-1:0]        cmp_idx_q;
  logic                 cmp_vld_q;
  logic [SLOTS-1:0]     valid_q;
  logic [SLOTS-1:0]     mask_q;
  logic                 nested_q;
  logic                 free_found_q;
  logic [AW-1:0]        free_idx_q;
  logic [REM_W-1:0]     rem_acc_q;
  logic [CNT_W-1:0]     rem_cnt_q;
  status_e              res_status_q;

  logic                 out_vld_q;
  status_e              out_status_q;
  logic [CNT_OUT_W-1:0] out_removed_q;
  logic [CNT_OUT_W-1:0] out_count_q;
  logic [SUM_W-1:0]     out_total_q;

  logic                 in_fire;
  logic                 out_free;
  logic                 ram_re, ram_we, load_out;
  acc_cmd_t             acc_cmd;
  logic [WORD_W-1:0]    rdata, wdata;
  logic [TIME_BITS-1:0] rd_start, rd_end;
  logic [UTIL_W-1:0]    rd_util;
  logic                 slot_v, is_inside, is_contain;
  logic [SUM_W-1:0]     total;
  logic [CNT_W-1:0]     count;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;

  assign rd_start = rdata[TIME_BITS-1:0];
  assign rd_end   = rdata[2*TIME_BITS-1:TIME_BITS];
  assign rd_util  = rdata[WORD_W-1:2*TIME_BITS];
  assign wdata    = {u_q, e_q, s_q};

  assign slot_v     = valid_q[cmp_idx_q];
  assign is_inside  = slot_v && (rd_start >= s_q) && (rd_end <= e_q);
  assign is_contain = slot_v && (rd_start <= s_q) && (rd_end >= e_q);

  misu_ram #(
    .WIDTH(WORD_W),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(free_idx_q),
    .wdata_i(wdata),
    .re_i   (ram_re),
    .raddr_i(addr_q),
    .rdata_o(rdata)
  );

  misu_acc #(
    .SLOTS(SLOTS)
  ) u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (acc_cmd),
    .sub_val_i(rem_acc_q),
    .sub_cnt_i(rem_cnt_q),
    .add_val_i(u_q),
    .total_o  (total),
    .count_o  (count)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (in_i.mode == MODE_CLEAR) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (addr_q == LAST) begin
          state_d = S_WRAP;
        end
      end
      S_WRAP: state_d = S_SUB;
      S_SUB:  state_d = S_ADD;
      S_ADD:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready    = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    load_out      = 1'b0;
    acc_cmd.clear = 1'b0;
    acc_cmd.sub   = 1'b0;
    acc_cmd.add   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_i.ready    = 1'b1;
        acc_cmd.clear = in_i.valid && (in_i.mode == MODE_CLEAR);
      end
      S_SCAN: ram_re = 1'b1;
      S_SUB:  acc_cmd.sub = !nested_q;
      S_ADD: begin
        ram_we      = !nested_q && free_found_q;
        acc_cmd.add = !nested_q && free_found_q;
      end
      S_DONE: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s_q <= TIME_BITS'(in_i.occ_start);
      e_q <= TIME_BITS'(in_i.occ_end);
      u_q <= in_i.occ_utility;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      addr_q       <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      valid_q      <= '0;
      mask_q       <= '0;
      nested_q     <= 1'b0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      rem_acc_q    <= '0;
      rem_cnt_q    <= '0;
      res_status_q <= STATUS_OK;
      out_vld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= ram_re;
      cmp_idx_q <= addr_q;

      if (in_fire) begin
        addr_q       <= '0;
        mask_q       <= '0;
        nested_q     <= 1'b0;
        free_found_q <= 1'b0;
        rem_acc_q    <= '0;
        rem_cnt_q    <= '0;
        res_status_q <= STATUS_OK;
        if (in_i.mode == MODE_CLEAR) begin
          valid_q <= '0;
        end
      end else if (ram_re) begin
        addr_q <= addr_q + AW'(1);
      end

      if (cmp_vld_q) begin
        if (is_inside) begin
          nested_q <= 1'b1;
        end
        if (is_contain) begin
          mask_q[cmp_idx_q] <= 1'b1;
          rem_acc_q         <= rem_acc_q + REM_W'(rd_util);
          rem_cnt_q         <= rem_cnt_q + CNT_W'(1);
        end
        if ((!slot_v || is_contain) && !free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q   <= cmp_idx_q;
        end
      end

      if (acc_cmd.sub) begin
        valid_q <= valid_q & ~mask_q;
      end

      if (state_q == S_SUB && nested_q) begin
        rem_cnt_q <= '0;
      end

      if (state_q == S_ADD) begin
        if (nested_q) begin
          res_status_q <= STATUS_NESTED;
        end else if (free_found_q) begin
          res_status_q        <= STATUS_OK;
          valid_q[free_idx_q] <= 1'b1;
        end else begin
          res_status_q <= STATUS_FULL;
        end
      end

      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q  <= res_status_q;
      out_removed_q <= CNT_OUT_W'(rem_cnt_q);
      out_count_q   <= CNT_OUT_W'(count);
      out_total_q   <= total;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.status        = out_status_q;
  assign out_o.removed_count = out_removed_q;
  assign out_o.entry_count   = out_count_q;
  assign out_o.total_utility = out_total_q;

`ifndef SYNTH
  a_write_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_ADD) && free_found_q && !nested_q)
    else $error("slot ram written without a free slot");

  a_full_removes_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && (res_status_q == STATUS_FULL) |-> (rem_cnt_q == '0))
    else $error("full status with removed intervals");

  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_SCAN) || (state_q == S_DONE))
    else $error("accepted item did not start work");
`endif

endmodule
